@@ rtl/core/sensor_request_response_framer_core_macros.svh @@
// assertion macros for the framer core
`ifndef SENSOR_REQUEST_RESPONSE_FRAMER_CORE_MACROS_SVH
`define SENSOR_REQUEST_RESPONSE_FRAMER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SRRF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SRRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SRRF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define SRRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/core/srrf_pkg.sv @@
package srrf_pkg;

	// item function codes
	typedef enum logic [1:0] {
		FUNC_START = 2'd0,
		FUNC_RX    = 2'd1,
		FUNC_TICK  = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	// transaction status codes
	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_TIMEOUT = 2'd1,
		STAT_CORRUPT = 2'd2
	} status_t;

	// result kind codes
	localparam logic KIND_TX   = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	localparam int REQ_LEN  = 7;
	localparam int BODY_LEN = 7;

	typedef logic [2:0] beat_idx_t;

	localparam beat_idx_t LAST_REQ_IDX = beat_idx_t'(REQ_LEN - 1);
	localparam beat_idx_t CKSUM_IDX    = beat_idx_t'(BODY_LEN - 1);

	localparam logic [7:0]  HDR_BYTE      = 8'hFF;
	localparam logic [15:0] TIMEOUT_RESET = 16'd10;
	localparam logic [15:0] TICK_MAX      = 16'hFFFF;

	// read request: header, id, length, read instruction, address, checksum
	localparam logic [7:0] REQ_ID    = 8'h00;
	localparam logic [7:0] REQ_LENF  = 8'h03;
	localparam logic [7:0] REQ_INSTR = 8'h02;
	localparam logic [7:0] REQ_ADDR  = 8'h00;
	localparam logic [7:0] REQ_CKSUM = ~(REQ_ID + REQ_LENF + REQ_INSTR + REQ_ADDR);

	localparam logic [7:0] REQ_BYTES [REQ_LEN] = '{
		HDR_BYTE, HDR_BYTE, REQ_ID, REQ_LENF, REQ_INSTR, REQ_ADDR, REQ_CKSUM
	};

	// result descriptor handed to the output stage
	typedef struct packed {
		logic        is_req;
		status_t     status;
		logic [31:0] value;
	} result_t;

	// engine status toward the pipeline control
	typedef struct packed {
		logic has_result;
		logic busy;
	} eng_flags_t;

endpackage

@@ rtl/core/srrf_engine.sv @@
module srrf_engine (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   go,
	input  logic [1:0]             func,
	input  logic [7:0]             rx_byte,
	input  logic [15:0]            timeout_ticks,
	output srrf_pkg::result_t      res,
	output srrf_pkg::eng_flags_t   flags
);

	logic                 busy_q, busy_d;
	logic                 header_q, header_d;
	logic                 prev_ff_q, prev_ff_d;
	srrf_pkg::beat_idx_t  count_q, count_d;
	logic [7:0]           sum_q, sum_d;
	logic [31:0]          shift_q, shift_d;
	logic [31:0]          good_q, good_d;
	logic [15:0]          tick_q, tick_d;
	logic [15:0]          tick_inc;
	logic                 hunt_clear;
	logic                 has_result;
	logic                 res_is_req;
	srrf_pkg::status_t    res_status;

	assign tick_inc = (tick_q == srrf_pkg::TICK_MAX) ? tick_q : tick_q + 16'd1;

	// next state and result for the item in the input register
	always_comb begin
		busy_d     = busy_q;
		header_d   = header_q;
		prev_ff_d  = prev_ff_q;
		count_d    = count_q;
		sum_d      = sum_q;
		shift_d    = shift_q;
		good_d     = good_q;
		tick_d     = tick_q;
		hunt_clear = 1'b0;
		has_result = 1'b0;
		res_is_req = 1'b0;
		res_status = srrf_pkg::STAT_OK;
		case (srrf_pkg::func_t'(func))
			srrf_pkg::FUNC_START: begin
				has_result = 1'b1;
				res_is_req = 1'b1;
				busy_d     = 1'b1;
				hunt_clear = 1'b1;
			end
			srrf_pkg::FUNC_RX: begin
				if (busy_q) begin
					if (!header_q) begin
						// header hunt
						if (prev_ff_q && rx_byte == srrf_pkg::HDR_BYTE) begin
							header_d  = 1'b1;
							count_d   = '0;
							sum_d     = '0;
							shift_d   = '0;
							prev_ff_d = 1'b0;
						end else begin
							prev_ff_d = (rx_byte == srrf_pkg::HDR_BYTE);
						end
					end else if (count_q < srrf_pkg::CKSUM_IDX) begin
						// body bytes: sum and shift in, newest on top
						sum_d   = sum_q + rx_byte;
						shift_d = {rx_byte, shift_q[31:8]};
						count_d = count_q + 3'd1;
					end else begin
						// checksum byte
						has_result = 1'b1;
						if (~sum_q == rx_byte) begin
							res_status = srrf_pkg::STAT_OK;
							good_d     = shift_q;
						end else begin
							res_status = srrf_pkg::STAT_CORRUPT;
						end
						busy_d     = 1'b0;
						hunt_clear = 1'b1;
					end
				end
			end
			srrf_pkg::FUNC_TICK: begin
				if (busy_q) begin
					if (tick_inc >= timeout_ticks) begin
						has_result = 1'b1;
						res_status = srrf_pkg::STAT_TIMEOUT;
						busy_d     = 1'b0;
						hunt_clear = 1'b1;
					end else begin
						tick_d = tick_inc;
					end
				end
			end
			default: begin
			end
		endcase
		if (hunt_clear) begin
			header_d  = 1'b0;
			prev_ff_d = 1'b0;
			count_d   = '0;
			sum_d     = '0;
			shift_d   = '0;
			tick_d    = '0;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			header_q  <= 1'b0;
			prev_ff_q <= 1'b0;
			count_q   <= '0;
			sum_q     <= '0;
			shift_q   <= '0;
			good_q    <= '0;
			tick_q    <= '0;
		end else if (go) begin
			busy_q    <= busy_d;
			header_q  <= header_d;
			prev_ff_q <= prev_ff_d;
			count_q   <= count_d;
			sum_q     <= sum_d;
			shift_q   <= shift_d;
			good_q    <= good_d;
			tick_q    <= tick_d;
		end
	end

	// outputs
	assign res.is_req       = res_is_req;
	assign res.status       = res_status;
	assign res.value        = good_d;
	assign flags.has_result = has_result;
	assign flags.busy       = busy_q;

endmodule

@@ rtl/core/sensor_request_response_framer_core.sv @@
// path: an item enters the input register, then its result enters the result register
// throughput: one item per cycle unless a result waits; a start item holds the output
//   for seven beats, items behind it that make no result keep flowing, others wait
// reset: all framer state, the kept value and the pipeline clear; timeout_ticks resets to 10
`include "sensor_request_response_framer_core_macros.svh"

module sensor_request_response_framer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [7:0]  tx_byte,
	output logic        last,
	output logic [1:0]  status,
	output logic [31:0] value,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic                  valid_s1;
	logic [1:0]            func_s1;
	logic [7:0]            rx_s1;
	logic                  adv_s1;
	logic                  out_free;
	logic                  out_final;
	logic [15:0]           timeout_q;
	srrf_pkg::result_t     eng_res;
	srrf_pkg::eng_flags_t  eng_flags;
	srrf_pkg::result_t     res_q;
	srrf_pkg::beat_idx_t   idx_q;
	logic                  out_valid_q;

	// timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= srrf_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	// output stage frees up when empty or when its final beat is taken
	assign out_final = !res_q.is_req || idx_q == srrf_pkg::LAST_REQ_IDX;
	assign out_free  = !out_valid_q || (out_ready && out_final);
	assign adv_s1    = valid_s1 && (!eng_flags.has_result || out_free);
	assign in_ready  = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1 <= func;
			rx_s1   <= rx_byte;
		end
	end

	srrf_engine u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.go            (adv_s1),
		.func          (func_s1),
		.rx_byte       (rx_s1),
		.timeout_ticks (timeout_q),
		.res           (eng_res),
		.flags         (eng_flags)
	);

	// result register and request burst counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (adv_s1 && eng_flags.has_result) begin
			out_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (out_valid_q && out_ready) begin
			if (out_final) begin
				out_valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && eng_flags.has_result) begin
			res_q <= eng_res;
		end
	end

	// result beat fields
	assign out_valid = out_valid_q;
	assign kind      = res_q.is_req ? srrf_pkg::KIND_TX : srrf_pkg::KIND_DONE;
	assign tx_byte   = res_q.is_req ? srrf_pkg::REQ_BYTES[idx_q] : 8'h00;
	assign last      = res_q.is_req && idx_q == srrf_pkg::LAST_REQ_IDX;
	assign status    = res_q.is_req ? 2'(srrf_pkg::STAT_OK) : 2'(res_q.status);
	assign value     = res_q.value;

	`SRRF_ASSERT_NEXT(a_burst_step, clk, arst_n, out_valid_q && out_ready && !out_final && !(adv_s1 && eng_flags.has_result), out_valid_q && idx_q == 3'($past(idx_q) + 3'd1), "request burst did not step")
	`SRRF_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid_q && !out_ready, out_valid_q && $stable(idx_q) && $stable(res_q), "stalled result beat changed")
	`SRRF_ASSERT_NEXT(a_done_idle, clk, arst_n, adv_s1 && eng_flags.has_result && !eng_res.is_req, !eng_flags.busy, "engine still busy after done result")
	`SRRF_ASSERT_NEXT(a_start_busy, clk, arst_n, adv_s1 && eng_res.is_req && eng_flags.has_result, eng_flags.busy, "engine not busy after start")

endmodule
